### src/bhpq_pkg.sv
// bhpq_pkg: shared constants, types and codes of the min-heap priority queue
// no dependencies; imported by bhpq_ctrl, the top level and the checker (bhpq_ram does not use it)
package bhpq_pkg;

    localparam int DEPTH       = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int PRIO_W      = 8;
    localparam int TASK_W      = 8;
    localparam int ENTRY_W     = PRIO_W + TASK_W;
    localparam int COUNT_OUT_W = 6;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXTRACTED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_PUT,
        S_DN_LOAD,
        S_DN_CMP
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TASK_W-1:0] task_id;
    } t_entry;

    // one write port shared by both copies, one read port on each copy
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_req;

endpackage

### src/bhpq_ram.sv
// bhpq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module bhpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bhpq_ctrl.sv
// bhpq_ctrl: sift sequencer of the heap, entry count and result word register
// depends on bhpq_pkg; drives the two mirrored heap rams
module bhpq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_op,
    input  logic [bhpq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [bhpq_pkg::TASK_W-1:0]  i_task_id,
    output logic                         o_busy,
    output bhpq_pkg::t_mem_req           o_mem,
    input  bhpq_pkg::t_entry             i_rd_a,
    input  bhpq_pkg::t_entry             i_rd_b,
    output logic                         o_done,
    output bhpq_pkg::t_status            o_status,
    output logic [bhpq_pkg::TASK_W-1:0]  o_task_id,
    output logic [bhpq_pkg::PRIO_W-1:0]  o_priority,
    output logic [bhpq_pkg::CNT_W-1:0]   o_count
);
    import bhpq_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_pos, n_pos;
    t_entry            r_new, n_new;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [TASK_W-1:0] r_otask, n_otask;
    logic [PRIO_W-1:0] r_oprio, n_oprio;
    logic [CNT_W-1:0]  r_ocount;

    logic              accept;
    logic [ADDR_W-1:0] parent_pos;
    logic [IDX_W-1:0]  left_idx, right_idx, child_idx;
    logic [IDX_W-1:0]  gc_left, gc_right;
    logic              left_ok, right_ok, use_right;
    t_entry            child;

    assign accept = i_start && (r_state == S_IDLE);

    // child selection for sift-down, left wins ties
    assign parent_pos = (r_pos - ADDR_W'(1)) >> 1;
    assign left_idx   = (IDX_W'(r_pos) << 1) + IDX_W'(1);
    assign right_idx  = left_idx + IDX_W'(1);
    assign left_ok    = left_idx < IDX_W'(r_count);
    assign right_ok   = right_idx < IDX_W'(r_count);
    assign use_right  = right_ok && (i_rd_b.prio < i_rd_a.prio);
    assign child      = use_right ? i_rd_b : i_rd_a;
    assign child_idx  = use_right ? right_idx : left_idx;
    assign gc_left    = (IDX_W'(ADDR_W'(child_idx)) << 1) + IDX_W'(1);
    assign gc_right   = gc_left + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pos    <= n_pos;
        r_new    <= n_new;
        r_status <= n_status;
        r_otask  <= n_otask;
        r_oprio  <= n_oprio;
        r_ocount <= n_count;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_new         = r_new;
        n_done        = 1'b0;
        n_status      = r_status;
        n_otask       = r_otask;
        n_oprio       = r_oprio;
        o_mem.we      = 1'b0;
        o_mem.waddr   = r_pos;
        o_mem.wdata   = r_new;
        o_mem.raddr_a = parent_pos;
        o_mem.raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_otask = '0;
                    n_oprio = '0;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_done   = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            n_count     = r_count + CNT_W'(1);
                            n_pos       = ADDR_W'(r_count);
                            n_new.prio  = i_priority_req;
                            n_new.task_id = i_task_id;
                            if (r_count == '0) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = '0;
                                o_mem.wdata = n_new;
                                n_done      = 1'b1;
                                n_status    = ST_INSERTED;
                            end else begin
                                o_mem.raddr_a = (ADDR_W'(r_count) - ADDR_W'(1)) >> 1;
                                n_state       = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_count       = r_count - CNT_W'(1);
                            o_mem.raddr_a = '0;
                            o_mem.raddr_b = ADDR_W'(r_count - CNT_W'(1));
                            n_state       = S_DN_LOAD;
                        end
                    end
                end
            end

            S_UP_CMP: begin
                // parent word is on port a; move it down while the new one is smaller
                if (r_new.prio < i_rd_a.prio) begin
                    o_mem.we      = 1'b1;
                    o_mem.wdata   = i_rd_a;
                    n_pos         = parent_pos;
                    o_mem.raddr_a = (parent_pos - ADDR_W'(1)) >> 1;
                    if (parent_pos == '0) begin
                        n_state = S_UP_PUT;
                    end
                end else begin
                    o_mem.we = 1'b1;
                    n_done   = 1'b1;
                    n_status = ST_INSERTED;
                    n_state  = S_IDLE;
                end
            end

            S_UP_PUT: begin
                o_mem.we = 1'b1;
                n_done   = 1'b1;
                n_status = ST_INSERTED;
                n_state  = S_IDLE;
            end

            S_DN_LOAD: begin
                // root on port a, last entry on port b; last becomes the moving word
                n_otask = i_rd_a.task_id;
                n_oprio = i_rd_a.prio;
                n_new   = i_rd_b;
                n_pos   = '0;
                if (r_count == '0) begin
                    n_done   = 1'b1;
                    n_status = ST_EXTRACTED;
                    n_state  = S_IDLE;
                end else begin
                    o_mem.raddr_a = ADDR_W'(1);
                    o_mem.raddr_b = ADDR_W'(2);
                    n_state       = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                if (left_ok && !(child.prio > r_new.prio)) begin
                    o_mem.we      = 1'b1;
                    o_mem.wdata   = child;
                    n_pos         = ADDR_W'(child_idx);
                    o_mem.raddr_a = ADDR_W'(gc_left);
                    o_mem.raddr_b = ADDR_W'(gc_right);
                end else begin
                    o_mem.we = 1'b1;
                    n_done   = 1'b1;
                    n_status = ST_EXTRACTED;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_task_id  = r_otask;
    assign o_priority = r_oprio;
    assign o_count    = r_ocount;

endmodule

### src/binary_min_heap_priority_queue_top.sv
// binary_min_heap_priority_queue_top: min-heap ready queue, two mirrored rams plus sequencer
// depends on bhpq_pkg, bhpq_ram, bhpq_ctrl
// sequence: full, empty and insert into an empty heap answer straight from idle; insert
// compares once per level climbed; extract loads root and last entry, stops if the heap is then empty, else sinks
// throughput: one command at a time, start is ignored while busy; one ram read/compare per heap level
// reset: synchronous active-low clears the entry count and sequencer; heap rams are not cleared
module binary_min_heap_priority_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [bhpq_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic [bhpq_pkg::TASK_W-1:0]         i_task_id,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [bhpq_pkg::TASK_W-1:0]         o_out_task_id,
    output logic [bhpq_pkg::PRIO_W-1:0]         o_out_priority,
    output logic [bhpq_pkg::COUNT_OUT_W-1:0]    o_count
);
    import bhpq_pkg::*;

    t_mem_req         mem_req;
    logic [ENTRY_W-1:0] rd_a, rd_b;
    t_status          status;
    logic [CNT_W-1:0] count;

    // both copies take every write, so each gives an independent read port
    // (sift-down reads both children of a node in the same cycle)
    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr_a),
        .o_rdata (rd_a)
    );

    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr_b),
        .o_rdata (rd_b)
    );

    // sifts keep a hole at the moving position: each step writes the node it
    // leaves and reads strictly deeper (down) or shallower (up) nodes, so a read
    // never hits the address written in the same cycle and no forwarding is needed
    bhpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_task_id      (i_task_id),
        .o_busy         (busy),
        .o_mem          (mem_req),
        .i_rd_a         (t_entry'(rd_a)),
        .i_rd_b         (t_entry'(rd_b)),
        .o_done         (o_done),
        .o_status       (status),
        .o_task_id      (o_out_task_id),
        .o_priority     (o_out_priority),
        .o_count        (count)
    );

    // result word: status code and count reported in the 6-bit field
    assign o_status = status;
    assign o_count  = COUNT_OUT_W'(count);

endmodule

### src/bhpq_checker.sv
// bhpq_checker: port-level assertions for the min-heap queue, bound to the top level
// depends on bhpq_pkg and binary_min_heap_priority_queue_top
module bhpq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_done,
    input logic [1:0]                       o_status,
    input logic [bhpq_pkg::TASK_W-1:0]      o_out_task_id,
    input logic [bhpq_pkg::PRIO_W-1:0]      o_out_priority,
    input logic [bhpq_pkg::COUNT_OUT_W-1:0] o_count
);
    import bhpq_pkg::*;

    // an accepted command either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command neither answered nor busy");

    // a word never appears while the sequencer is still working
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while busy");

    // only an extract carries an entry
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_EXTRACTED) |->
            (o_out_task_id == '0 && o_out_priority == '0))
        else $error("nonzero entry on a non-extract word");

    // full and empty answers agree with the reported count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_count == COUNT_OUT_W'(DEPTH)))
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind binary_min_heap_priority_queue_top bhpq_checker u_bhpq_checker (.*);
